@@ design/mersenne_twister_generator_top_defines.svh @@
// Assertion macros for the MT19937 generator.
// Used by mersenne_twister_generator_top; needs no other file.
`ifndef MERSENNE_TWISTER_GENERATOR_TOP_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define MTG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mtg: check failed");
`define MTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mtg: check failed");
`else
`define MTG_ASSERT(lbl, clk, rst_n, prop)
`define MTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/mtg_pkg.sv @@
// Shared types, constants and the tempering function of the MT19937 generator.
// Depends on nothing; used by mtg_front, mtg_back and the top level.
`timescale 1ns / 1ps
`default_nettype none
package mtg_pkg;
	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
	localparam logic [31:0] INIT_MUL     = 32'd1812433253;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc60000;

	localparam logic [1:0] CMD_SEED   = 2'd0;
	localparam logic [1:0] CMD_DRAW32 = 2'd1;
	localparam logic [1:0] CMD_DRAW64 = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		OP_SEED,
		OP_DRAW32,
		OP_DRAW64
	} op_t;

	typedef struct packed {
		logic        valid;
		op_t         op;
		logic [31:0] seed;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SD_FIRST,
		ST_SD_MUL,
		ST_SD_WR,
		ST_TW_INIT,
		ST_TW_LOAD,
		ST_TW_FAR,
		ST_TW_WR,
		ST_DR_RD,
		ST_DR_TEMP
	} back_state_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] r;
		r = w ^ (w >> 11);
		r = r ^ ((r << 7) & TEMPER_B);
		r = r ^ ((r << 15) & TEMPER_C);
		r = r ^ (r >> 18);
		return r;
	endfunction
endpackage
`default_nettype wire

@@ design/mtg_stream_if.sv @@
// Request and response channel interfaces of the MT19937 generator.
// Self-contained; used by the front, the back and the top level.
`timescale 1ns / 1ps
`default_nettype none
interface mtg_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] seed_value;
	modport source (output valid, output cmd, output seed_value, input ready);
	modport sink (input valid, input cmd, input seed_value, output ready);
endinterface

interface mtg_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] random_value;
	modport source (output valid, output random_value, input ready);
	modport sink (input valid, input random_value, output ready);
endinterface
`default_nettype wire

@@ design/mtg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ design/mtg_front.sv @@
// Front of the MT19937 generator: takes requests, classifies them, queues jobs.
// Depends on mtg_pkg and mtg_req_if.
`timescale 1ns / 1ps
`default_nettype none
module mtg_front (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mtg_req_if.sink     req,
	output mtg_pkg::job_t job,
	input  wire logic   pop
);
	localparam int QD = mtg_pkg::QUEUE_DEPTH;
	localparam int PW = (QD > 1) ? $clog2(QD) : 1;
	localparam int CW = $clog2(QD + 1);

	mtg_pkg::op_t op_q [QD];
	logic [31:0]  seed_q [QD];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          accept, enq, deq;
	mtg_pkg::op_t  op_in;

	assign req.ready = (cnt_q != CW'(QD));
	assign accept    = req.valid && req.ready;
	assign enq       = accept && (req.cmd != mtg_pkg::CMD_UNUSED);
	assign deq       = pop && (cnt_q != '0);

	always_comb begin
		case (req.cmd)
			mtg_pkg::CMD_SEED:   op_in = mtg_pkg::OP_SEED;
			mtg_pkg::CMD_DRAW32: op_in = mtg_pkg::OP_DRAW32;
			default:             op_in = mtg_pkg::OP_DRAW64;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= (wr_q == PW'(QD - 1)) ? '0 : wr_q + 1'b1;
			end
			if (deq) begin
				rd_q <= (rd_q == PW'(QD - 1)) ? '0 : rd_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			op_q[wr_q]   <= op_in;
			seed_q[wr_q] <= req.seed_value;
		end
	end

	assign job.valid = (cnt_q != '0);
	assign job.op    = op_q[rd_q];
	assign job.seed  = seed_q[rd_q];
endmodule
`default_nettype wire

@@ design/mtg_back.sv @@
// Back of the MT19937 generator: seeding, bulk twist, tempered draws, response register.
// Depends on mtg_pkg, mtg_rsp_if and mtg_ram.
`timescale 1ns / 1ps
`default_nettype none
module mtg_back #(
	parameter int STATE_WORDS  = mtg_pkg::STATE_WORDS,
	parameter int TWIST_OFFSET = mtg_pkg::TWIST_OFFSET
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mtg_pkg::job_t job,
	output logic               pop,
	mtg_rsp_if.source          rsp
);
	localparam int AW = $clog2(STATE_WORDS);
	localparam int IW = $clog2(STATE_WORDS + 1);
	localparam logic [AW-1:0] LAST      = AW'(STATE_WORDS - 1);
	localparam logic [IW-1:0] FULL_IDX  = IW'(STATE_WORDS);
	localparam logic [AW-1:0] FAR_START = AW'(TWIST_OFFSET % STATE_WORDS);

	mtg_pkg::back_state_t state_q, state_d;

	logic [IW-1:0] idx_q;
	logic [AW-1:0] k_q, nk_q, far_q;
	logic [31:0]   cur_q, nxt_q, p_q, prod_q, hi_q;
	logic          wide_q, second_q;
	logic          out_valid_q;
	logic [63:0]   out_data_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;

	logic [AW-1:0] nk_inc, far_inc, draw_idx;
	logic [IW-1:0] idx_inc;
	logic [31:0]   y, twist_word, seed_word, tempered;
	logic          out_free, idx_at_end, first_half;

	mtg_ram #(
		.WIDTH (32),
		.DEPTH (STATE_WORDS)
	) u_words (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign nk_inc     = (nk_q == LAST) ? '0 : nk_q + 1'b1;
	assign far_inc    = (far_q == LAST) ? '0 : far_q + 1'b1;
	assign idx_inc    = idx_q + 1'b1;
	assign draw_idx   = idx_q[AW-1:0];
	assign y          = {cur_q[31], nxt_q[30:0]};
	assign twist_word = rdata ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_MATRIX : 32'h0);
	assign seed_word  = prod_q + 32'(k_q);
	assign tempered   = mtg_pkg::temper(rdata);
	assign out_free   = !out_valid_q || rsp.ready;
	assign idx_at_end = (idx_q >= FULL_IDX);
	assign first_half = wide_q && !second_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mtg_pkg::ST_IDLE: begin
				if (job.valid) begin
					case (job.op)
						mtg_pkg::OP_SEED:   state_d = mtg_pkg::ST_SD_FIRST;
						mtg_pkg::OP_DRAW32,
						mtg_pkg::OP_DRAW64: state_d = idx_at_end ? mtg_pkg::ST_TW_INIT
						                                         : mtg_pkg::ST_DR_RD;
						default:            state_d = mtg_pkg::ST_IDLE;
					endcase
				end
			end
			mtg_pkg::ST_SD_FIRST: state_d = mtg_pkg::ST_SD_MUL;
			mtg_pkg::ST_SD_MUL:   state_d = mtg_pkg::ST_SD_WR;
			mtg_pkg::ST_SD_WR:    state_d = (k_q == LAST) ? mtg_pkg::ST_IDLE : mtg_pkg::ST_SD_MUL;
			mtg_pkg::ST_TW_INIT:  state_d = mtg_pkg::ST_TW_LOAD;
			mtg_pkg::ST_TW_LOAD:  state_d = mtg_pkg::ST_TW_FAR;
			mtg_pkg::ST_TW_FAR:   state_d = mtg_pkg::ST_TW_WR;
			mtg_pkg::ST_TW_WR:    state_d = (k_q == LAST) ? mtg_pkg::ST_DR_RD : mtg_pkg::ST_TW_FAR;
			mtg_pkg::ST_DR_RD:    state_d = mtg_pkg::ST_DR_TEMP;
			mtg_pkg::ST_DR_TEMP: begin
				if (first_half) begin
					state_d = (idx_inc >= FULL_IDX) ? mtg_pkg::ST_TW_INIT : mtg_pkg::ST_DR_RD;
				end else if (out_free) begin
					state_d = mtg_pkg::ST_IDLE;
				end
			end
			default: state_d = mtg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop   = 1'b0;
		we    = 1'b0;
		waddr = k_q;
		wdata = seed_word;
		raddr = '0;
		case (state_q)
			mtg_pkg::ST_IDLE:     pop = job.valid;
			mtg_pkg::ST_SD_FIRST: begin
				we    = 1'b1;
				waddr = '0;
				wdata = p_q;
			end
			mtg_pkg::ST_SD_WR:    we = 1'b1;
			mtg_pkg::ST_TW_LOAD:  raddr = nk_q;
			mtg_pkg::ST_TW_FAR:   raddr = far_q;
			mtg_pkg::ST_TW_WR: begin
				we    = 1'b1;
				wdata = twist_word;
				raddr = nk_inc;
			end
			mtg_pkg::ST_DR_RD,
			mtg_pkg::ST_DR_TEMP:  raddr = draw_idx;
			default:              raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtg_pkg::ST_IDLE;
			idx_q       <= FULL_IDX;
			wide_q      <= 1'b0;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mtg_pkg::ST_DR_TEMP && !first_half && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				mtg_pkg::ST_IDLE: begin
					if (job.valid) begin
						wide_q   <= (job.op == mtg_pkg::OP_DRAW64);
						second_q <= 1'b0;
					end
				end
				mtg_pkg::ST_SD_FIRST: idx_q <= FULL_IDX;
				mtg_pkg::ST_TW_WR: begin
					if (k_q == LAST) begin
						idx_q <= '0;
					end
				end
				mtg_pkg::ST_DR_TEMP: begin
					if (first_half) begin
						idx_q    <= idx_inc;
						second_q <= 1'b1;
					end else if (out_free) begin
						idx_q <= idx_inc;
					end
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mtg_pkg::ST_IDLE: begin
				if (job.valid) begin
					p_q <= job.seed;
				end
			end
			mtg_pkg::ST_SD_FIRST: k_q <= AW'(1);
			mtg_pkg::ST_SD_MUL:   prod_q <= mtg_pkg::INIT_MUL * (p_q ^ (p_q >> 30));
			mtg_pkg::ST_SD_WR: begin
				p_q <= seed_word;
				k_q <= k_q + 1'b1;
			end
			mtg_pkg::ST_TW_INIT: begin
				k_q   <= '0;
				nk_q  <= AW'(1);
				far_q <= FAR_START;
			end
			mtg_pkg::ST_TW_LOAD:  cur_q <= rdata;
			mtg_pkg::ST_TW_FAR:   nxt_q <= rdata;
			mtg_pkg::ST_TW_WR: begin
				cur_q <= nxt_q;
				k_q   <= k_q + 1'b1;
				nk_q  <= nk_inc;
				far_q <= far_inc;
			end
			mtg_pkg::ST_DR_TEMP: begin
				if (first_half) begin
					hi_q <= tempered;
				end else if (out_free) begin
					out_data_q <= wide_q ? {hi_q, tempered} : {32'h0, tempered};
				end
			end
			default: cur_q <= cur_q;
		endcase
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.random_value = out_data_q;
endmodule
`default_nettype wire

@@ design/mersenne_twister_generator_top.sv @@
// MT19937 generator top. A draw passes the request queue, the word memory read and the tempering
// into the response register; a 64-bit draw reads and tempers two words, high word first.
// Two requests queue ahead; the back takes the next job only once the last response is registered.
// A draw that finds the state used up first twists it, with two reads per word on the one read port.
// Seed: one multiply and one write per word.
// Reset clears control and the queue and marks the state used up; words undefined until seeded.
`timescale 1ns / 1ps
`default_nettype none
`include "mersenne_twister_generator_top_defines.svh"
module mersenne_twister_generator_top #(
	parameter int STATE_WORDS  = mtg_pkg::STATE_WORDS,
	parameter int TWIST_OFFSET = mtg_pkg::TWIST_OFFSET
) (
	input wire logic  clk,
	input wire logic  arst_n,
	mtg_req_if.sink   req,
	mtg_rsp_if.source rsp
);
	mtg_pkg::job_t job;
	logic          pop;
	logic          seed_fire, unused_fire;

	assign seed_fire   = req.valid && req.ready && (req.cmd == mtg_pkg::CMD_SEED);
	assign unused_fire = req.valid && req.ready && (req.cmd == mtg_pkg::CMD_UNUSED);

	mtg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.job    (job),
		.pop    (pop)
	);

	mtg_back #(
		.STATE_WORDS  (STATE_WORDS),
		.TWIST_OFFSET (TWIST_OFFSET)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.pop    (pop),
		.rsp    (rsp)
	);

	`MTG_ASSERT(a_pop_needs_job, clk, arst_n, pop |-> job.valid)
	`MTG_ASSERT_NEXT(a_seed_queued, clk, arst_n, seed_fire && !job.valid, job.valid)
	`MTG_ASSERT_NEXT(a_unused_dropped, clk, arst_n, unused_fire && !job.valid, !job.valid)
endmodule
`default_nettype wire
